/* rtl/twcd_pkg.sv */
// ----------------------------------------------------------------------------
// twcd_pkg: shared types, codes and tables
// Payload structs, entity match codes and the pending-letter tables used by
// the whitespace-collapse / entity-decode filter.
// ----------------------------------------------------------------------------
package twcd_pkg;

  // Most results one input byte can cause
  localparam int unsigned MaxRes   = 5;
  // Default depth of the queue between front and back
  localparam int unsigned QDepth   = 4;

  localparam logic [7:0] ChCr      = 8'h0D;
  localparam logic [7:0] ChTab     = 8'h09;
  localparam logic [7:0] ChSpace   = 8'h20;
  localparam logic [7:0] ChLf      = 8'h0A;
  localparam logic [7:0] ChAmp     = 8'h26;
  localparam logic [7:0] ChLt      = 8'h3C;
  localparam logic [7:0] ChGt      = 8'h3E;
  localparam logic [7:0] ChSemi    = 8'h3B;
  localparam logic [7:0] ChL       = 8'h6C;
  localparam logic [7:0] ChT       = 8'h74;
  localparam logic [7:0] ChG       = 8'h67;
  localparam logic [7:0] ChA       = 8'h61;
  localparam logic [7:0] ChM       = 8'h6D;
  localparam logic [7:0] ChP       = 8'h70;
  localparam logic [7:0] BadEntity = 8'hFF;

  // Entity match codes
  localparam logic [3:0] EmNone = 4'd0;  // no entity in progress
  localparam logic [3:0] EmAmp  = 4'd1;  // "&"
  localparam logic [3:0] EmL    = 4'd2;  // "&l"
  localparam logic [3:0] EmLt   = 4'd3;  // "&lt"
  localparam logic [3:0] EmG    = 4'd4;  // "&g"
  localparam logic [3:0] EmGt   = 4'd5;  // "&gt"
  localparam logic [3:0] EmA    = 4'd6;  // "&a"
  localparam logic [3:0] EmAm   = 4'd7;  // "&am"
  localparam logic [3:0] EmAmpx = 4'd8;  // "&amp"

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       out_last;
  } out_t;

  // One queue entry: all results of one input byte
  typedef struct packed {
    logic [MaxRes-1:0][7:0] bytes;
    logic [2:0]             cnt;   // number of results, 1..MaxRes
    logic                   bare;  // single bare end marker
    logic                   last;  // final result carries the end flag
  } desc_t;

  // Letters held by a partial match
  function automatic logic [1:0] pend_len(logic [3:0] em);
    logic [1:0] len;
    case (em)
      EmL, EmG, EmA:   len = 2'd1;
      EmLt, EmGt, EmAm: len = 2'd2;
      EmAmpx:          len = 2'd3;
      default:         len = 2'd0;
    endcase
    return len;
  endfunction

  function automatic logic [7:0] pend_chr(logic [3:0] em, logic [1:0] idx);
    logic [7:0] ch;
    ch = 8'h00;
    case (em)
      EmL, EmLt: ch = (idx == 2'd0) ? ChL : ChT;
      EmG, EmGt: ch = (idx == 2'd0) ? ChG : ChT;
      EmA, EmAm, EmAmpx: begin
        case (idx)
          2'd0:    ch = ChA;
          2'd1:    ch = ChM;
          default: ch = ChP;
        endcase
      end
      default:   ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic is_ws(logic [7:0] c);
    return (c == ChCr) || (c == ChTab) || (c == ChSpace) || (c == ChLf);
  endfunction

endpackage

/* rtl/text_whitespace_collapse_entity_decode.sv */
// ----------------------------------------------------------------------------
// text_whitespace_collapse_entity_decode: text filter top level
// Drops leading whitespace, collapses whitespace runs to one space and
// decodes &lt; &gt; &amp; in a byte stream, one byte per transaction.
//
//   channel   direction  handshake           payload
//   input     in         push / full         in_i  (in_byte, in_last)
//   result    out        pop  / empty        out_o (out_byte, byte_valid,
//                                                   out_last)
//
// Cycles: a byte is taken every cycle while the entry queue has room; the
// front classifies it in the same cycle. Each byte causes 0..5 results and
// the back hands out one result per cycle while pop is held, so a byte with
// k results holds the result side for k pops; sustained input rate is one
// byte per cycle while the stream averages at most one result per byte.
// Reset: asynchronous, active low; space-run flag set, no entity pending,
// queue empty. Stalls: full rises only when the entry queue (Depth entries)
// is full; a held pop leaves the front free to keep accepting.
// ----------------------------------------------------------------------------
module text_whitespace_collapse_entity_decode #(
  parameter int unsigned Depth = twcd_pkg::QDepth
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  twcd_pkg::in_t  in_i,
  input  logic           push,
  output logic           full,
  output twcd_pkg::out_t out_o,
  output logic           empty,
  input  logic           pop
);

  twcd_pkg::desc_t desc;
  twcd_pkg::desc_t head;
  logic            desc_push;
  logic            head_pop;
  logic            head_empty;
  logic            accept;

  // accept a transaction whenever the queue can take its entry
  assign accept = push && !full;

  twcd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .accept_i    (accept),
    .desc_o      (desc),
    .desc_push_o (desc_push)
  );

  // hold entries until the back has sent every result
  twcd_fifo #(
    .Depth (Depth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (desc_push),
    .wdata_i (desc),
    .pop_i   (head_pop),
    .rdata_o (head),
    .full_o  (full),
    .empty_o (head_empty)
  );

  // advance through the head entry one result per transaction
  twcd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .head_empty_i (head_empty),
    .head_pop_o   (head_pop),
    .out_o        (out_o),
    .empty_o      (empty),
    .pop_i        (pop)
  );

  // a bare end marker always closes a string and carries no character
  a_bare_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !out_o.byte_valid) |-> (out_o.out_last && (out_o.out_byte == 8'h00)))
    else $error("bare end marker without end flag or with a character");

  // the final byte of a string always leaves at least one result queued
  a_last_queues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !full && in_i.in_last) |=> !empty)
    else $error("end of string produced no result");

  // a taken result that is not the end of its entry leaves that entry on offer
  a_entry_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !empty && !head_pop) |=> !empty)
    else $error("entry dropped before all results were sent");

endmodule

/* rtl/twcd_front.sv */
// ----------------------------------------------------------------------------
// twcd_front: byte classifier
// Tracks the space-run and entity-match state and turns each accepted byte
// that causes results into one queue entry holding all of them.
// ----------------------------------------------------------------------------
module twcd_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  twcd_pkg::in_t    in_i,
  input  logic             accept_i,
  output twcd_pkg::desc_t  desc_o,
  output logic             desc_push_o
);

  logic                                  sr_q, sr_d;
  logic [3:0]                            em_q, em_d;
  logic [twcd_pkg::MaxRes-1:0][7:0]      slots;
  logic [2:0]                            n;
  logic                                  hit;
  logic                                  bare;
  logic [7:0]                            c;

  assign c = in_i.in_byte;

  always_comb begin
    slots = '0;
    n     = 3'd0;
    sr_d  = sr_q;
    em_d  = em_q;
    hit   = 1'b0;
    bare  = 1'b0;

    // advance a match in progress
    if (em_q != twcd_pkg::EmNone) begin
      case (em_q)
        twcd_pkg::EmL, twcd_pkg::EmG: begin
          if (c == twcd_pkg::ChT) begin
            hit  = 1'b1;
            em_d = em_q + 4'd1;
          end
        end
        twcd_pkg::EmLt, twcd_pkg::EmGt, twcd_pkg::EmAmpx: begin
          if (c == twcd_pkg::ChSemi) begin
            hit      = 1'b1;
            em_d     = twcd_pkg::EmNone;
            slots[n] = (em_q == twcd_pkg::EmLt) ? twcd_pkg::ChLt :
                       (em_q == twcd_pkg::EmGt) ? twcd_pkg::ChGt : twcd_pkg::ChAmp;
            n        = n + 3'd1;
          end
        end
        twcd_pkg::EmA: begin
          if (c == twcd_pkg::ChM) begin
            hit  = 1'b1;
            em_d = twcd_pkg::EmAm;
          end
        end
        twcd_pkg::EmAm: begin
          if (c == twcd_pkg::ChP) begin
            hit  = 1'b1;
            em_d = twcd_pkg::EmAmpx;
          end
        end
        default: begin
          if (c == twcd_pkg::ChL) begin
            hit  = 1'b1;
            em_d = twcd_pkg::EmL;
          end else if (c == twcd_pkg::ChG) begin
            hit  = 1'b1;
            em_d = twcd_pkg::EmG;
          end else if (c == twcd_pkg::ChA) begin
            hit  = 1'b1;
            em_d = twcd_pkg::EmA;
          end
        end
      endcase

      // broken match: flush marker and held letters
      if (!hit) begin
        slots[n] = twcd_pkg::BadEntity;
        n        = n + 3'd1;
        for (int i = 0; i < 3; i++) begin
          if (2'(i) < twcd_pkg::pend_len(em_q)) begin
            slots[n] = twcd_pkg::pend_chr(em_q, 2'(i));
            n        = n + 3'd1;
          end
        end
        em_d = twcd_pkg::EmNone;
        sr_d = 1'b0;
      end
    end

    // ordinary byte
    if (!hit) begin
      if (twcd_pkg::is_ws(c)) begin
        if (!sr_d) begin
          slots[n] = twcd_pkg::ChSpace;
          n        = n + 3'd1;
        end
        sr_d = 1'b1;
      end else if (c == twcd_pkg::ChAmp) begin
        em_d = twcd_pkg::EmAmp;
        sr_d = 1'b0;
      end else begin
        slots[n] = c;
        n        = n + 3'd1;
        sr_d     = 1'b0;
      end
    end

    // end of string: flush, mark, restart
    if (in_i.in_last) begin
      if (em_d != twcd_pkg::EmNone) begin
        slots[n] = twcd_pkg::BadEntity;
        n        = n + 3'd1;
        for (int i = 0; i < 3; i++) begin
          if (2'(i) < twcd_pkg::pend_len(em_d)) begin
            slots[n] = twcd_pkg::pend_chr(em_d, 2'(i));
            n        = n + 3'd1;
          end
        end
      end
      if (n == 3'd0) begin
        bare = 1'b1;
        n    = 3'd1;
      end
      sr_d = 1'b1;
      em_d = twcd_pkg::EmNone;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sr_q <= 1'b1;
      em_q <= twcd_pkg::EmNone;
    end else if (accept_i) begin
      sr_q <= sr_d;
      em_q <= em_d;
    end
  end

  assign desc_o.bytes = slots;
  assign desc_o.cnt   = n;
  assign desc_o.bare  = bare;
  assign desc_o.last  = in_i.in_last;
  assign desc_push_o  = accept_i && (n != 3'd0);

endmodule

/* rtl/twcd_fifo.sv */
// ----------------------------------------------------------------------------
// twcd_fifo: entry queue
// Short first-in first-out queue of result entries between front and back.
// ----------------------------------------------------------------------------
module twcd_fifo #(
  parameter int unsigned Depth = twcd_pkg::QDepth
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  twcd_pkg::desc_t wdata_i,
  input  logic            pop_i,
  output twcd_pkg::desc_t rdata_o,
  output logic            full_o,
  output logic            empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  twcd_pkg::desc_t   mem_q [Depth];
  logic [PtrW-1:0]   wr_q, rd_q;
  logic [CntW-1:0]   cnt_q;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

/* rtl/twcd_back.sv */
// ----------------------------------------------------------------------------
// twcd_back: result serialiser
// Walks the head queue entry one result per transaction and releases the
// entry after its final result.
// ----------------------------------------------------------------------------
module twcd_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  twcd_pkg::desc_t head_i,
  input  logic            head_empty_i,
  output logic            head_pop_o,
  output twcd_pkg::out_t  out_o,
  output logic            empty_o,
  input  logic            pop_i
);

  logic [2:0] idx_q, idx_d;
  logic       at_end;
  logic       take;

  assign empty_o = head_empty_i;
  assign take    = pop_i && !head_empty_i;
  assign at_end  = (idx_q == head_i.cnt - 3'd1);

  assign out_o.out_byte   = head_i.bare ? 8'h00 : head_i.bytes[idx_q];
  assign out_o.byte_valid = !head_i.bare;
  assign out_o.out_last   = head_i.last && at_end;

  assign head_pop_o = take && at_end;

  always_comb begin
    idx_d = idx_q;
    if (take) begin
      idx_d = at_end ? 3'd0 : idx_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= 3'd0;
    end else begin
      idx_q <= idx_d;
    end
  end

endmodule
